@@ rtl/desched_pkg.sv @@
// shared types, codes and defaults of the disk elevator request scheduler
package desched_pkg;

    localparam int ADDR_W            = 32;
    localparam int TAG_W             = 6;
    localparam int PEND_W            = 5;
    localparam int DEF_TABLE_DEPTH   = 16;
    localparam int DEF_TAG_BITS      = 6;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_DONE    = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] block_address;
        logic [TAG_W-1:0]  requester_tag;
    } t_in_beat;

    typedef struct packed {
        logic              grant_valid;
        logic [TAG_W-1:0]  grant_tag;
        logic              rejected;
        logic              sweep_up;
        logic [PEND_W-1:0] pending_count;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sel;
        logic upd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic full;
        logic found;
    } t_dp_sts;

endpackage

@@ rtl/desched_ctrl.sv @@
// sequencing state machine and result valid of the disk elevator scheduler
module desched_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  desched_pkg::t_dp_sts i_sts,
    output desched_pkg::t_dp_cmd o_cmd
);
    import desched_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_room;

    assign w_room     = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cmp    = (r_state == S_CMP);
        o_cmd.sel    = (r_state == S_SEL);
        o_cmd.upd    = (r_state == S_UPD) && w_room;
        o_cmd.commit = (i_sts.op == OP_DONE) ? i_sts.found : !i_sts.full;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_room) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/desched_dp.sv @@
// sorted request table with parallel compare and shift, sweep state and result register
module desched_dp #(
    parameter int TABLE_DEPTH = desched_pkg::DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = desched_pkg::DEF_TAG_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  desched_pkg::t_in_beat  i_in,
    input  desched_pkg::t_dp_cmd   i_cmd,
    output desched_pkg::t_dp_sts   o_sts,
    output desched_pkg::t_out_beat o_out
);
    import desched_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [ADDR_W-1:0]   r_addr_tbl [TABLE_DEPTH];
    logic [TAG_BITS-1:0] r_tag_tbl  [TABLE_DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_dir;
    logic                n_dir;

    logic                r_op;
    logic [ADDR_W-1:0]   r_key_addr;
    logic [TAG_BITS-1:0] r_key_tag;

    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] r_hit;
    logic [TABLE_DEPTH-1:0] w_neg;
    logic [TABLE_DEPTH-1:0] w_ins;
    logic [TABLE_DEPTH-1:0] w_bnd;
    logic [TABLE_DEPTH-1:0] r_mask;
    logic [TABLE_DEPTH-1:0] r_first;

    logic                w_has_next;
    logic                w_has_prev;
    logic [TAG_BITS-1:0] w_next_tag;
    logic [TAG_BITS-1:0] w_prev_tag;
    t_out_beat           r_out;
    t_out_beat           n_out;

    // occupancy and per-entry compare
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_valid[i] = (CNT_W'(i) < r_count);
            if (r_op == OP_DONE) begin
                w_hit[i] = w_valid[i] && (r_tag_tbl[i] == r_key_tag);
            end else begin
                w_hit[i] = w_valid[i] && (r_addr_tbl[i] <= r_key_addr);
            end
        end
    end

    // shift masks: insert boundary, or first match and everything above it
    always_comb begin
        w_neg    = ~r_hit + TABLE_DEPTH'(1);
        w_ins    = ~r_hit;
        w_bnd[0] = w_ins[0];
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            w_bnd[i] = w_ins[i] && !w_ins[i-1];
        end
    end

    // neighbours of the removed entry
    always_comb begin
        w_has_next = 1'b0;
        w_next_tag = '0;
        w_prev_tag = '0;
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
            w_has_next = w_has_next | (r_first[i] & w_valid[i+1]);
            w_next_tag = w_next_tag | (r_tag_tbl[i+1] & {TAG_BITS{r_first[i]}});
        end
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            w_prev_tag = w_prev_tag | (r_tag_tbl[i-1] & {TAG_BITS{r_first[i]}});
        end
        w_has_prev = !r_first[0];
    end

    always_comb begin
        n_count             = r_count;
        n_dir               = r_dir;
        n_out               = '0;
        if (!i_cmd.commit) begin
            n_out.rejected = 1'b1;
        end else if (r_op == OP_REQUEST) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == '0) begin
                n_out.grant_valid = 1'b1;
                n_out.grant_tag   = TAG_W'(r_key_tag);
            end
        end else begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_dir = 1'b1;
            end else begin
                n_out.grant_valid = 1'b1;
                if (r_dir) begin
                    if (w_has_next) begin
                        n_out.grant_tag = TAG_W'(w_next_tag);
                    end else begin
                        n_dir           = 1'b0;
                        n_out.grant_tag = TAG_W'(w_prev_tag);
                    end
                end else begin
                    if (w_has_prev) begin
                        n_out.grant_tag = TAG_W'(w_prev_tag);
                    end else begin
                        n_dir           = 1'b1;
                        n_out.grant_tag = TAG_W'(w_next_tag);
                    end
                end
            end
        end
        n_out.sweep_up      = n_dir;
        n_out.pending_count = PEND_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in.command;
            r_key_addr <= i_in.block_address;
            r_key_tag  <= TAG_BITS'(i_in.requester_tag);
        end
        if (i_cmd.cmp) begin
            r_hit <= w_hit;
        end
        if (i_cmd.sel) begin
            if (r_op == OP_DONE) begin
                r_mask  <= r_hit | w_neg;
                r_first <= r_hit & w_neg;
            end else begin
                r_mask  <= w_ins;
                r_first <= w_bnd;
            end
        end
        if (i_cmd.upd) begin
            r_out <= n_out;
        end
        if (i_cmd.upd && i_cmd.commit) begin
            if (r_op == OP_REQUEST) begin
                if (r_first[0]) begin
                    r_addr_tbl[0] <= r_key_addr;
                    r_tag_tbl[0]  <= r_key_tag;
                end
                for (int i = 1; i < TABLE_DEPTH; i++) begin
                    if (r_first[i]) begin
                        r_addr_tbl[i] <= r_key_addr;
                        r_tag_tbl[i]  <= r_key_tag;
                    end else if (r_mask[i]) begin
                        r_addr_tbl[i] <= r_addr_tbl[i-1];
                        r_tag_tbl[i]  <= r_tag_tbl[i-1];
                    end
                end
            end else begin
                for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                    if (r_mask[i]) begin
                        r_addr_tbl[i] <= r_addr_tbl[i+1];
                        r_tag_tbl[i]  <= r_tag_tbl[i+1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dir   <= 1'b1;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
            r_dir   <= n_dir;
        end
    end

    assign o_sts.op    = r_op;
    assign o_sts.full  = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.found = |r_hit;
    assign o_out       = r_out;

endmodule

@@ rtl/disk_elevator_request_scheduler_unit.sv @@
// top level of the disk elevator request scheduler
// result: made valid by the table update, which waits while a held result stalls
// one beat at a time, in order: load, compare, mask select, table update
// the result register lets the next beat enter while a result waits
// reset: table empty, sweep ascending, no result pending; table contents keep no reset
module disk_elevator_request_scheduler_unit #(
    parameter int TABLE_DEPTH = desched_pkg::DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = desched_pkg::DEF_TAG_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  desched_pkg::t_in_beat  i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output desched_pkg::t_out_beat o_out
);
    import desched_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    desched_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    desched_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out)
    );

    a_new_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 4))
        else $error("result appeared without an input beat four cycles before");

    a_grant_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.grant_valid && o_out.rejected))
        else $error("result both granted and rejected");

    a_no_grant_zero_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.grant_valid) |-> (o_out.grant_tag == '0))
        else $error("grant tag set without a grant");

    a_busy_while_working: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while previous beat still in work");

endmodule
